[src/hrhp_pkg.sv]
// Package: constants and helper functions shared by the header parser modules.
package hrhp_pkg;

	localparam int HEADER_LIMIT_DEF = 1024;
	localparam int LENGTH_BITS_DEF = 16;
	localparam logic [32:0] MAG_CAP = 33'h0_8000_0000;

	// status reader steps
	localparam logic [3:0] ST_U1_WS = 4'd0;
	localparam logic [3:0] ST_U1_SIGN = 4'd1;
	localparam logic [3:0] ST_U1_DIG = 4'd2;
	localparam logic [3:0] ST_U2_WS = 4'd3;
	localparam logic [3:0] ST_U2_SIGN = 4'd4;
	localparam logic [3:0] ST_U2_DIG = 4'd5;
	localparam logic [3:0] ST_D_WS = 4'd6;
	localparam logic [3:0] ST_D_SIGN = 4'd7;
	localparam logic [3:0] ST_D_DIG = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;
	localparam logic [3:0] ST_FAIL = 4'd10;

	// length reader steps
	localparam logic [1:0] LS_WS = 2'd0;
	localparam logic [1:0] LS_SIGN = 2'd1;
	localparam logic [1:0] LS_DIG = 2'd2;
	localparam logic [1:0] LS_END = 2'd3;

	// phases
	localparam logic [1:0] PH_SEEK = 2'd0;
	localparam logic [1:0] PH_HEAD = 2'd1;
	localparam logic [1:0] PH_BODY = 2'd2;

	localparam logic [1:0] ERR_OK = 2'd0;
	localparam logic [1:0] ERR_MALFORMED = 2'd1;
	localparam logic [1:0] ERR_TOO_LONG = 2'd2;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  error_code;
		logic [15:0] start_offset;
		logic signed [31:0] resp_status;
		logic signed [31:0] resp_length;
		logic [15:0] head_bytes;
		logic [15:0] body_bytes;
		logic        complete;
	} out_item_t;

	// number reader state handed from the reader to the result logic
	typedef struct packed {
		logic        ok;
		logic signed [31:0] status;
		logic signed [31:0] length;
	} nums_t;

	function automatic logic is_ws(input logic [7:0] c);
		return (c == 8'h20) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_sign(input logic [7:0] c);
		return (c == 8'h2B) || (c == 8'h2D);
	endfunction

	function automatic logic [7:0] low_case(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
	endfunction

	function automatic logic [7:0] key_char(input logic [3:0] i);
		logic [7:0] r;
		case (i)
			4'd0: r = "c";
			4'd1: r = "o";
			4'd2: r = "n";
			4'd3: r = "t";
			4'd4: r = "e";
			4'd5: r = "n";
			4'd6: r = "t";
			4'd7: r = "-";
			4'd8: r = "l";
			4'd9: r = "e";
			4'd10: r = "n";
			4'd11: r = "g";
			4'd12: r = "t";
			4'd13: r = "h";
			default: r = ":";
		endcase
		return r;
	endfunction

	function automatic logic [7:0] marker_char(input logic [2:0] i);
		logic [7:0] r;
		case (i)
			3'd0: r = "H";
			3'd1: r = "T";
			3'd2: r = "T";
			3'd3: r = "P";
			default: r = "/";
		endcase
		return r;
	endfunction

	// decimal accumulate with saturation at 2^31 (shift-add, no multiplier)
	function automatic logic [31:0] acc(input logic [31:0] mag, input logic [7:0] c);
		logic [35:0] m;
		m = ({4'd0, mag} << 3) + ({4'd0, mag} << 1) + {32'd0, c[3:0]};
		return (m > {3'd0, MAG_CAP}) ? MAG_CAP[31:0] : m[31:0];
	endfunction

	function automatic logic signed [31:0] to_signed(input logic [31:0] mag, input logic neg);
		logic signed [31:0] r;
		if (neg)
			r = mag[31] ? 32'sh8000_0000 : -$signed(mag);
		else
			r = mag[31] ? 32'sh7FFF_FFFF : $signed(mag);
		return r;
	endfunction

endpackage

[src/hrhp_if.sv]
// Interface: valid/ready channel carrying one payload.
interface hrhp_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

[src/hrhp_numbers.sv]
// Status and Content-Length readers working on header bytes.
module hrhp_numbers (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        feed,
	input  logic        clear,
	input  logic [7:0]  c,
	output hrhp_pkg::nums_t now_q,
	output hrhp_pkg::nums_t next_v
);
	logic [3:0]  st_step_q, st_step_d;
	logic [31:0] st_val_q, st_val_d;
	logic        st_neg_q, st_neg_d;
	logic [3:0]  key_q, key_d;
	logic [1:0]  ls_q, ls_d;
	logic [31:0] len_q, len_d;
	logic        len_neg_q, len_neg_d;
	logic [7:0]  lc;

	assign lc = hrhp_pkg::low_case(c);

	// advance both readers by one byte
	always_comb begin
		st_step_d = st_step_q;
		st_val_d = st_val_q;
		st_neg_d = st_neg_q;
		key_d = key_q;
		ls_d = ls_q;
		len_d = len_q;
		len_neg_d = len_neg_q;
		if (feed) begin
			case (st_step_q)
				hrhp_pkg::ST_U1_WS, hrhp_pkg::ST_U2_WS: begin
					if (!hrhp_pkg::is_ws(c)) begin
						if (hrhp_pkg::is_sign(c)) st_step_d = st_step_q + 4'd1;
						else if (hrhp_pkg::is_dig(c)) st_step_d = st_step_q + 4'd2;
						else st_step_d = hrhp_pkg::ST_FAIL;
					end
				end
				hrhp_pkg::ST_U1_SIGN, hrhp_pkg::ST_U2_SIGN: begin
					st_step_d = hrhp_pkg::is_dig(c) ? st_step_q + 4'd1 : hrhp_pkg::ST_FAIL;
				end
				hrhp_pkg::ST_U1_DIG: begin
					if (c == ".") st_step_d = hrhp_pkg::ST_U2_WS;
					else if (!hrhp_pkg::is_dig(c)) st_step_d = hrhp_pkg::ST_FAIL;
				end
				hrhp_pkg::ST_U2_DIG, hrhp_pkg::ST_D_WS: begin
					if (!(hrhp_pkg::is_dig(c) && st_step_q == hrhp_pkg::ST_U2_DIG)) begin
						if (hrhp_pkg::is_ws(c)) st_step_d = hrhp_pkg::ST_D_WS;
						else if (hrhp_pkg::is_sign(c)) begin
							st_neg_d = (c == "-");
							st_step_d = hrhp_pkg::ST_D_SIGN;
						end else if (hrhp_pkg::is_dig(c)) begin
							st_val_d = hrhp_pkg::acc(st_val_q, c);
							st_step_d = hrhp_pkg::ST_D_DIG;
						end else st_step_d = hrhp_pkg::ST_FAIL;
					end
				end
				hrhp_pkg::ST_D_SIGN: begin
					if (hrhp_pkg::is_dig(c)) begin
						st_val_d = hrhp_pkg::acc(st_val_q, c);
						st_step_d = hrhp_pkg::ST_D_DIG;
					end else st_step_d = hrhp_pkg::ST_FAIL;
				end
				hrhp_pkg::ST_D_DIG: begin
					if (hrhp_pkg::is_dig(c)) st_val_d = hrhp_pkg::acc(st_val_q, c);
					else st_step_d = hrhp_pkg::ST_DONE;
				end
				default: ;
			endcase
			if (key_q < 4'd15) begin
				if (lc == hrhp_pkg::key_char(key_q)) key_d = key_q + 4'd1;
				else key_d = (lc == "c") ? 4'd1 : 4'd0;
			end else begin
				case (ls_q)
					hrhp_pkg::LS_WS: begin
						if (!hrhp_pkg::is_ws(c)) begin
							if (hrhp_pkg::is_sign(c)) begin
								len_neg_d = (c == "-");
								ls_d = hrhp_pkg::LS_SIGN;
							end else if (hrhp_pkg::is_dig(c)) begin
								len_d = hrhp_pkg::acc(len_q, c);
								ls_d = hrhp_pkg::LS_DIG;
							end else ls_d = hrhp_pkg::LS_END;
						end
					end
					hrhp_pkg::LS_SIGN, hrhp_pkg::LS_DIG: begin
						if (hrhp_pkg::is_dig(c)) begin
							len_d = hrhp_pkg::acc(len_q, c);
							ls_d = hrhp_pkg::LS_DIG;
						end else ls_d = hrhp_pkg::LS_END;
					end
					default: ;
				endcase
			end
		end
	end

	// results for the state before and after this byte
	always_comb begin
		now_q.ok = (st_step_q == hrhp_pkg::ST_D_DIG) || (st_step_q == hrhp_pkg::ST_DONE);
		now_q.status = hrhp_pkg::to_signed(st_val_q, st_neg_q);
		now_q.length = (key_q == 4'd15) ? hrhp_pkg::to_signed(len_q, len_neg_q) : -32'sd1;
		next_v.ok = (st_step_d == hrhp_pkg::ST_D_DIG) || (st_step_d == hrhp_pkg::ST_DONE);
		next_v.status = hrhp_pkg::to_signed(st_val_d, st_neg_d);
		next_v.length = (key_d == 4'd15) ? hrhp_pkg::to_signed(len_d, len_neg_d) : -32'sd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_step_q <= hrhp_pkg::ST_U1_WS;
			st_val_q <= '0;
			st_neg_q <= 1'b0;
			key_q <= '0;
			ls_q <= hrhp_pkg::LS_WS;
			len_q <= '0;
			len_neg_q <= 1'b0;
		end else if (clear) begin
			st_step_q <= hrhp_pkg::ST_U1_WS;
			st_val_q <= '0;
			st_neg_q <= 1'b0;
			key_q <= '0;
			ls_q <= hrhp_pkg::LS_WS;
			len_q <= '0;
			len_neg_q <= 1'b0;
		end else begin
			st_step_q <= st_step_d;
			st_val_q <= st_val_d;
			st_neg_q <= st_neg_d;
			key_q <= key_d;
			ls_q <= ls_d;
			len_q <= len_d;
			len_neg_q <= len_neg_d;
		end
	end
endmodule

[src/http_response_header_parser.sv]
// Top level: byte-stream HTTP response header parser.
// Usage:
//  - in: one byte a transfer (data_byte, last_byte). Every byte is taken;
//    only the byte with last_byte set yields a result.
//  - out: one result per buffer (error code, offsets, status, length,
//    header/body lengths, completeness).
//  - Each byte passes through one stage of matcher and decimal-accumulate
//    logic and lands in the result register, or in the skid register while
//    a result waits; throughput one byte per cycle while in.ready is high.
//  - A result waiting in the output register does not stop input; a second
//    result goes to a skid register, and while that is full in.ready is low
//    for every byte until the receiver takes the waiting result.
//  - Reset clears all parsing state and empties the output registers;
//    after each result the parsing state returns to reset for the next
//    buffer.
//  - When the receiver stalls, the result holds on out until taken.
//  - Counters saturate at 2^LENGTH_BITS - 1; headers of HEADER_LIMIT - 1
//    bytes or more report as too long.
module http_response_header_parser #(
	parameter int HEADER_LIMIT = hrhp_pkg::HEADER_LIMIT_DEF,
	parameter int LENGTH_BITS = hrhp_pkg::LENGTH_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	hrhp_if.sink in,
	hrhp_if.source out
);
	localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;
	localparam logic [32:0] LIMIT_M1 = 33'(HEADER_LIMIT - 1);

	hrhp_pkg::in_item_t ib;
	logic [7:0] c;
	logic       last, take;

	logic [1:0] phase_q;
	logic [2:0] mark_q;
	logic [LENGTH_BITS-1:0] skip_q, pos_q, crlf_end_q, snap_len_q;
	logic [1:0] crlf_q;
	logic       prev_lf_q, zero_q;
	logic       snap_taken_q, snap_ok_q;
	logic signed [31:0] snap_st_q, snap_cl_q;

	logic [1:0] phase_d;
	logic [2:0] mark_d;
	logic [LENGTH_BITS-1:0] skip_d, pos_d, crlf_end_d, pos_inc;
	logic [1:0] crlf_d;
	logic       prev_lf_d, zero_d, crlf_hit, lf_hit, feed;

	hrhp_pkg::nums_t nums_now, nums_next;
	hrhp_pkg::out_item_t res;

	logic       out_valid_q, skid_valid_q;
	hrhp_pkg::out_item_t out_q, skid_q;

	assign ib = in.payload;
	assign c = ib.data_byte;
	assign last = ib.last_byte;
	assign in.ready = !skid_valid_q;
	assign take = in.valid && in.ready;

	assign pos_inc = (pos_q == LEN_MAX) ? pos_q : pos_q + 1'b1;
	assign feed = take && (phase_q == hrhp_pkg::PH_HEAD) && !(zero_q || c == 8'd0);

	hrhp_numbers u_numbers (
		.clk(clk), .arst_n(arst_n), .feed(feed), .clear(take && last), .c(c),
		.now_q(nums_now), .next_v(nums_next)
	);

	// advance the marker, terminator and position trackers
	always_comb begin
		phase_d = phase_q;
		mark_d = mark_q;
		skip_d = skip_q;
		pos_d = pos_q;
		crlf_d = crlf_q;
		prev_lf_d = prev_lf_q;
		zero_d = zero_q;
		crlf_end_d = crlf_end_q;
		crlf_hit = 1'b0;
		lf_hit = 1'b0;
		case (phase_q)
			hrhp_pkg::PH_SEEK: begin
				skip_d = (skip_q == LEN_MAX) ? skip_q : skip_q + 1'b1;
				if (c == hrhp_pkg::marker_char(mark_q)) mark_d = mark_q + 3'd1;
				else mark_d = (c == "H") ? 3'd1 : 3'd0;
				if (mark_d >= 3'd5) begin
					phase_d = hrhp_pkg::PH_HEAD;
					pos_d = LENGTH_BITS'(5);
					skip_d = (skip_d >= LENGTH_BITS'(5)) ? skip_d - LENGTH_BITS'(5) : '0;
				end
			end
			hrhp_pkg::PH_HEAD: begin
				pos_d = pos_inc;
				if (c == 8'd0) zero_d = 1'b1;
				if (c == (crlf_q[0] ? 8'h0A : 8'h0D)) begin
					crlf_d = crlf_q + 2'd1;
					if (crlf_q == 2'd3) crlf_hit = 1'b1;
				end else begin
					crlf_d = (c == 8'h0D) ? 2'd1 : 2'd0;
				end
				lf_hit = (c == 8'h0A) && prev_lf_q;
				prev_lf_d = (c == 8'h0A);
				if (crlf_hit) begin
					crlf_end_d = pos_inc;
					phase_d = hrhp_pkg::PH_BODY;
				end
			end
			default: pos_d = pos_inc;
		endcase
	end

	// form the result from the state after this byte
	always_comb begin
		logic have, pok;
		logic [LENGTH_BITS-1:0] hlen, bl;
		logic signed [31:0] pst, pcl;
		logic [32:0] hl_ext;
		have = 1'b0;
		pok = 1'b0;
		hlen = '0;
		pst = -32'sd1;
		pcl = -32'sd1;
		res.error_code = hrhp_pkg::ERR_MALFORMED;
		res.start_offset = '0;
		res.resp_status = -32'sd1;
		res.resp_length = -32'sd1;
		res.head_bytes = '0;
		res.body_bytes = '0;
		res.complete = 1'b0;
		bl = '0;
		if (phase_d != hrhp_pkg::PH_SEEK) begin
			res.start_offset = (LENGTH_BITS > 16 && skip_d > LENGTH_BITS'(16'hFFFF)) ?
				16'hFFFF : 16'(skip_d);
			if (phase_d == hrhp_pkg::PH_BODY) begin
				have = 1'b1;
				hlen = crlf_end_d;
				pok = nums_next.ok;
				pst = nums_next.status;
				pcl = nums_next.length;
				if (phase_q == hrhp_pkg::PH_BODY) begin
					pok = nums_now.ok;
					pst = nums_now.status;
					pcl = nums_now.length;
				end
			end else if (snap_taken_q) begin
				have = 1'b1;
				hlen = snap_len_q;
				pok = snap_ok_q;
				pst = snap_st_q;
				pcl = snap_cl_q;
			end else if (lf_hit) begin
				have = 1'b1;
				hlen = pos_d;
				pok = nums_next.ok;
				pst = nums_next.status;
				pcl = nums_next.length;
			end
		end
		hl_ext = 33'(hlen);
		if (have) begin
			res.head_bytes = (LENGTH_BITS > 16 && hlen > LENGTH_BITS'(16'hFFFF)) ?
				16'hFFFF : 16'(hlen);
			if (hl_ext >= LIMIT_M1 || hlen == LEN_MAX) begin
				res.error_code = hrhp_pkg::ERR_TOO_LONG;
			end else if (pok) begin
				res.error_code = hrhp_pkg::ERR_OK;
				res.resp_status = pst;
				res.resp_length = pcl;
				bl = pos_d - hlen;
				if (!pcl[31]) begin
					if ({{(32-LENGTH_BITS){1'b0}}, bl} >= pcl) begin
						res.complete = 1'b1;
						bl = LENGTH_BITS'(pcl);
					end
				end else begin
					res.complete = (bl != '0);
				end
				res.body_bytes = (LENGTH_BITS > 16 && bl > LENGTH_BITS'(16'hFFFF)) ?
					16'hFFFF : 16'(bl);
			end
		end
	end

	// hold tracker state; return to reset after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hrhp_pkg::PH_SEEK;
			mark_q <= '0;
			skip_q <= '0;
			pos_q <= '0;
			crlf_q <= '0;
			prev_lf_q <= 1'b0;
			zero_q <= 1'b0;
			crlf_end_q <= '0;
			snap_taken_q <= 1'b0;
			snap_ok_q <= 1'b0;
			snap_st_q <= -32'sd1;
			snap_cl_q <= -32'sd1;
			snap_len_q <= '0;
		end else if (take) begin
			if (last) begin
				phase_q <= hrhp_pkg::PH_SEEK;
				mark_q <= '0;
				skip_q <= '0;
				pos_q <= '0;
				crlf_q <= '0;
				prev_lf_q <= 1'b0;
				zero_q <= 1'b0;
				crlf_end_q <= '0;
				snap_taken_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				mark_q <= mark_d;
				skip_q <= skip_d;
				pos_q <= pos_d;
				crlf_q <= crlf_d;
				prev_lf_q <= prev_lf_d;
				zero_q <= zero_d;
				crlf_end_q <= crlf_end_d;
				if (phase_q == hrhp_pkg::PH_HEAD && !crlf_hit && lf_hit && !snap_taken_q)
				begin
					snap_taken_q <= 1'b1;
					snap_ok_q <= nums_next.ok;
					snap_st_q <= nums_next.status;
					snap_cl_q <= nums_next.length;
					snap_len_q <= pos_d;
				end
			end
		end
	end

	// result register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out.ready) begin
				out_valid_q <= skid_valid_q || (take && last);
				skid_valid_q <= 1'b0;
			end else if (take && last) begin
				if (out_valid_q) skid_valid_q <= 1'b1;
				else out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_valid_q && out.ready) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (take && last) begin
			if (out_valid_q) skid_q <= res;
			else out_q <= res;
		end
	end

	assign out.valid = out_valid_q;
	assign out.payload = out_q;
endmodule
